// ===== hdl/aibst_pkg.sv =====
package aibst_pkg;

  localparam int TREE_SLOTS_DEF = 1024;
  localparam int KEY_BITS_DEF   = 48;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 3;
  localparam int SLOT_FIELD_W   = 10;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_NO_ROOM   = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_CLEARED   = 3'd5,
    STAT_ZERO_KEY  = 3'd6
  } status_t;

  // work kinds handed from the front to the back
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REPLY  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    status_t  status;
  } op_ctl_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// ===== hdl/aibst_ram.sv =====
module aibst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/aibst_front.sv =====
module aibst_front #(
  parameter int KEY_BITS = aibst_pkg::KEY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aibst_pkg::cmd_t        in_cmd,
  input  logic [KEY_BITS-1:0]    in_key,
  input  aibst_pkg::back_stat_t  stat,
  output logic                   op_valid,
  input  logic                   op_ready,
  output aibst_pkg::op_ctl_t     op_ctl,
  output logic [KEY_BITS-1:0]    op_key
);

  aibst_pkg::op_ctl_t q_ctl [aibst_pkg::QUEUE_DEPTH];
  logic [KEY_BITS-1:0] q_key [aibst_pkg::QUEUE_DEPTH];

  logic [aibst_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [aibst_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [aibst_pkg::QUEUE_CNT_W-1:0] count;

  aibst_pkg::op_ctl_t cls;
  logic push;
  logic pop;

  // classify the incoming command
  always_comb begin
    cls.kind   = aibst_pkg::OP_REPLY;
    cls.status = aibst_pkg::STAT_NOT_FOUND;
    case (in_cmd)
      aibst_pkg::CMD_CLEAR: begin
        cls.kind = aibst_pkg::OP_CLEAR;
      end
      aibst_pkg::CMD_INSERT, aibst_pkg::CMD_FIND: begin
        if (in_key == '0) begin
          cls.status = aibst_pkg::STAT_ZERO_KEY;
        end else if (in_cmd == aibst_pkg::CMD_INSERT) begin
          cls.kind = aibst_pkg::OP_INSERT;
        end else begin
          cls.kind = aibst_pkg::OP_FIND;
        end
      end
      default: begin
        cls.kind = aibst_pkg::OP_REPLY;
      end
    endcase
  end

  assign in_ready = (count != aibst_pkg::QUEUE_CNT_W'(aibst_pkg::QUEUE_DEPTH)) &&
                    !stat.init_busy;
  assign push     = in_valid && in_ready;
  assign op_valid = (count != '0);
  assign pop      = op_valid && op_ready;
  assign op_ctl   = q_ctl[rd_ptr];
  assign op_key   = q_key[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl[wr_ptr] <= cls;
      q_key[wr_ptr] <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == aibst_pkg::QUEUE_PTR_W'(aibst_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == aibst_pkg::QUEUE_PTR_W'(aibst_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/aibst_back.sv =====
module aibst_back #(
  parameter int TREE_SLOTS = aibst_pkg::TREE_SLOTS_DEF,
  parameter int KEY_BITS   = aibst_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op_valid,
  output logic                                op_ready,
  input  aibst_pkg::op_ctl_t                  op_ctl,
  input  logic [KEY_BITS-1:0]                 op_key,
  output aibst_pkg::back_stat_t               stat,
  output logic                                res_valid,
  input  logic                                res_ready,
  output aibst_pkg::status_t                  res_status,
  output logic [KEY_BITS-1:0]                 res_key,
  output logic [aibst_pkg::SLOT_FIELD_W-1:0]  res_slot
);

  localparam int AW = $clog2(TREE_SLOTS);
  localparam int CW = AW + 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_REPLY = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] pos, pos_next;
  logic init_busy, init_busy_next;
  logic is_insert, is_insert_next;
  logic [KEY_BITS-1:0] key, key_next;
  aibst_pkg::status_t pend_status, pend_status_next;
  logic [KEY_BITS-1:0] pend_key, pend_key_next;
  logic [AW-1:0] pend_pos, pend_pos_next;

  logic we;
  logic [KEY_BITS-1:0] wdata;
  logic [KEY_BITS-1:0] cur;
  logic [CW-1:0] child;
  logic out_free;
  logic [AW+aibst_pkg::SLOT_FIELD_W-1:0] pend_pos_ext;

  aibst_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TREE_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(pos),
    .wdata(wdata),
    .raddr(pos_next),
    .rdata(cur)
  );

  assign out_free       = !res_valid || res_ready;
  assign op_ready       = (state == ST_IDLE);
  assign stat.init_busy = init_busy;
  assign pend_pos_ext   = {{aibst_pkg::SLOT_FIELD_W{1'b0}}, pend_pos};

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    init_busy_next   = init_busy;
    is_insert_next   = is_insert;
    key_next         = key;
    pend_status_next = pend_status;
    pend_key_next    = pend_key;
    pend_pos_next    = pend_pos;
    we               = 1'b0;
    wdata            = '0;
    child            = (key < cur) ? (CW'(pos) << 1) + CW'(1) : (CW'(pos) << 1) + CW'(2);

    case (state)
      ST_IDLE: begin
        pend_key_next = '0;
        pend_pos_next = '0;
        if (op_valid) begin
          is_insert_next   = (op_ctl.kind == aibst_pkg::OP_INSERT);
          key_next         = op_key;
          pend_status_next = op_ctl.status;
          case (op_ctl.kind)
            aibst_pkg::OP_INSERT, aibst_pkg::OP_FIND: begin
              state_next = ST_WALK;
            end
            aibst_pkg::OP_CLEAR: begin
              pend_status_next = aibst_pkg::STAT_CLEARED;
              state_next       = ST_SWEEP;
            end
            default: begin
              state_next = ST_REPLY;
            end
          endcase
        end
      end
      ST_WALK: begin
        // one tree level per cycle, memory read runs one step ahead
        if (cur == '0) begin
          if (is_insert) begin
            we               = 1'b1;
            wdata            = key;
            pend_status_next = aibst_pkg::STAT_INSERTED;
            pend_pos_next    = pos;
          end else begin
            pend_status_next = aibst_pkg::STAT_NOT_FOUND;
          end
          pos_next   = '0;
          state_next = ST_REPLY;
        end else if (key == cur) begin
          if (is_insert) begin
            pend_status_next = aibst_pkg::STAT_DUPLICATE;
          end else begin
            pend_status_next = aibst_pkg::STAT_FOUND;
            pend_key_next    = cur;
          end
          pend_pos_next = pos;
          pos_next      = '0;
          state_next    = ST_REPLY;
        end else if (child >= CW'(TREE_SLOTS)) begin
          pend_status_next = is_insert ? aibst_pkg::STAT_NO_ROOM : aibst_pkg::STAT_NOT_FOUND;
          pos_next         = '0;
          state_next       = ST_REPLY;
        end else begin
          pos_next = child[AW-1:0];
        end
      end
      ST_SWEEP: begin
        we = 1'b1;
        if (pos == AW'(TREE_SLOTS - 1)) begin
          pos_next       = '0;
          init_busy_next = 1'b0;
          state_next     = init_busy ? ST_IDLE : ST_REPLY;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        pos_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      pos       <= '0;
      init_busy <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      init_busy <= init_busy_next;
      if (state == ST_REPLY && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_insert   <= is_insert_next;
    key         <= key_next;
    pend_status <= pend_status_next;
    pend_key    <= pend_key_next;
    pend_pos    <= pend_pos_next;
    if (state == ST_REPLY && out_free) begin
      res_status <= pend_status;
      res_key    <= pend_key;
      res_slot   <= pend_pos_ext[aibst_pkg::SLOT_FIELD_W-1:0];
    end
  end

endmodule

// ===== hdl/implicit_array_bst_insert_find.sv =====
// binary search tree of nonzero keys kept in a heap-indexed array
// (root in slot 0, children of slot i in 2i+1 and 2i+2, zero means empty)
// input channel s_*: tuser carries the command (insert, find, clear),
//   tdata the key; a transaction takes place when tvalid and tready are high
// output channel m_*: one result transaction per input transaction, in order;
//   tuser carries the status, tdata the found key and the slot number
// a front stage classifies each command into a two-entry queue; the back
//   stage walks the tree one level per cycle through the node memory
//   (registered read, the next address is issued while the current level
//   is compared)
// work: an insert or find walks d levels (d <= clog2(TREE_SLOTS+1)), then
//   replies; a clear sweeps every slot to zero, then replies; zero keys and
//   the unused command go straight to the reply; one item is worked at a
//   time, and the back stage takes no new command until the last is replied
// reset: the back stage first sweeps all TREE_SLOTS slots to zero, one slot
//   a cycle, and s_tready stays low until that sweep is done
// stall: the result sits in an output register; while m_tready is low the
//   back stage holds its next result, and the queue keeps taking commands
//   until it is full
module implicit_array_bst_insert_find #(
  parameter int TREE_SLOTS = aibst_pkg::TREE_SLOTS_DEF,
  parameter int KEY_BITS   = aibst_pkg::KEY_BITS_DEF,
  localparam int IN_W      = ((KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((KEY_BITS + aibst_pkg::SLOT_FIELD_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,  // key
  input  logic [aibst_pkg::CMD_W-1:0]   s_tuser,  // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,  // found_key, slot_index
  output logic [aibst_pkg::STATUS_W-1:0] m_tuser  // status
);

  aibst_pkg::cmd_t       in_cmd;
  aibst_pkg::back_stat_t stat;
  aibst_pkg::op_ctl_t    op_ctl;
  logic                  op_valid;
  logic                  op_ready;
  logic [KEY_BITS-1:0]   op_key;

  aibst_pkg::status_t                  res_status;
  logic [KEY_BITS-1:0]                 res_key;
  logic [aibst_pkg::SLOT_FIELD_W-1:0]  res_slot;

  assign in_cmd = aibst_pkg::cmd_t'(s_tuser);

  // front: accepts and classifies commands into a short queue
  aibst_front #(
    .KEY_BITS(KEY_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_cmd  (in_cmd),
    .in_key  (s_tdata[KEY_BITS-1:0]),
    .stat    (stat),
    .op_valid(op_valid),
    .op_ready(op_ready),
    .op_ctl  (op_ctl),
    .op_key  (op_key)
  );

  // back: tree walk, clearing sweep and the output register
  aibst_back #(
    .TREE_SLOTS(TREE_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op_ctl    (op_ctl),
    .op_key    (op_key),
    .stat      (stat),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_status(res_status),
    .res_key   (res_key),
    .res_slot  (res_slot)
  );

  // pack found_key in the low bits, slot_index above, zero fill to bytes
  always_comb begin
    m_tdata = '0;
    m_tdata[KEY_BITS-1:0] = res_key;
    m_tdata[KEY_BITS +: aibst_pkg::SLOT_FIELD_W] = res_slot;
  end

  assign m_tuser = res_status;

endmodule

// ===== sim/implicit_array_bst_insert_find_tb.sv =====
module implicit_array_bst_insert_find_tb;

  localparam int KEY_W        = aibst_pkg::KEY_BITS_DEF;
  localparam int SLOTS        = aibst_pkg::TREE_SLOTS_DEF;
  localparam int OUT_W        = ((KEY_W + aibst_pkg::SLOT_FIELD_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_LIMIT  = 6000;
  localparam int DRAIN_CYCLES = 40;

  typedef bit [KEY_W-1:0]                   key_t;
  typedef bit [aibst_pkg::SLOT_FIELD_W-1:0] slot_t;

  typedef struct packed {
    aibst_pkg::status_t status;
    key_t               found_key;
    slot_t              slot_index;
  } reply_t;

  // how fresh keys are drawn within one tree episode
  typedef enum int {
    KEYS_WIDE,
    KEYS_CLUSTER,
    KEYS_RISING,
    KEYS_FALLING,
    KEYS_NARROW
  } key_style_t;

  localparam key_t KEY_MAX = '1;

  class bst_scoreboard;
    key_t   node_mirror [SLOTS];
    reply_t pending_replies [$];
    int     mismatches;

    function new();
      foreach (node_mirror[i]) node_mirror[i] = '0;
      mismatches = 0;
    endfunction

    // walk the mirrored tree exactly as the block does and update it
    function reply_t walk_tree(aibst_pkg::cmd_t cmd, key_t key);
      reply_t r;
      int     pos;
      bit     done;
      r = '0;
      if (cmd == aibst_pkg::CMD_CLEAR) begin
        foreach (node_mirror[i]) node_mirror[i] = '0;
        r.status = aibst_pkg::STAT_CLEARED;
      end else if (cmd == aibst_pkg::CMD_UNUSED) begin
        r.status = aibst_pkg::STAT_NOT_FOUND;
      end else if (key == '0) begin
        r.status = aibst_pkg::STAT_ZERO_KEY;
      end else begin
        if (cmd == aibst_pkg::CMD_INSERT) r.status = aibst_pkg::STAT_NO_ROOM;
        else r.status = aibst_pkg::STAT_NOT_FOUND;
        pos  = 0;
        done = 1'b0;
        while (!done && pos < SLOTS) begin
          if (node_mirror[pos] == '0) begin
            if (cmd == aibst_pkg::CMD_INSERT) begin
              node_mirror[pos] = key;
              r.status     = aibst_pkg::STAT_INSERTED;
              r.slot_index = slot_t'(pos);
            end
            done = 1'b1;
          end else if (key < node_mirror[pos]) begin
            pos = 2 * pos + 1;
          end else if (key > node_mirror[pos]) begin
            pos = 2 * pos + 2;
          end else begin
            if (cmd == aibst_pkg::CMD_INSERT) begin
              r.status = aibst_pkg::STAT_DUPLICATE;
            end else begin
              r.status    = aibst_pkg::STAT_FOUND;
              r.found_key = node_mirror[pos];
            end
            r.slot_index = slot_t'(pos);
            done = 1'b1;
          end
        end
      end
      return r;
    endfunction

    function void note_command(aibst_pkg::cmd_t cmd, key_t key);
      reply_t r;
      r = walk_tree(cmd, key);
      pending_replies = {pending_replies, r};
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_reply(logic [aibst_pkg::STATUS_W-1:0] status, logic [OUT_W-1:0] data);
      reply_t                             exp;
      logic [KEY_W-1:0]                   got_key;
      logic [aibst_pkg::SLOT_FIELD_W-1:0] got_slot;
      got_key  = data[KEY_W-1:0];
      got_slot = data[KEY_W +: aibst_pkg::SLOT_FIELD_W];
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result (status %0d) with no command waiting", status));
        return;
      end
      exp = pending_replies.pop_front();
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %s", status, exp.status.name()));
      if (got_key !== exp.found_key)
        report_mismatch($sformatf("found_key %0h, expected %0h", got_key, exp.found_key));
      if (got_slot !== exp.slot_index)
        report_mismatch($sformatf("slot_index %0d, expected %0d", got_slot,
                                  exp.slot_index));
    endtask
  endclass

  logic                           clk;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [KEY_W-1:0]               s_tdata  = '0;  // key
  logic [aibst_pkg::CMD_W-1:0]    s_tuser  = '0;  // command
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [OUT_W-1:0]               m_tdata;        // found_key, slot_index
  logic [aibst_pkg::STATUS_W-1:0] m_tuser;        // status

  bst_scoreboard sb = new();
  int            quiet_cycles = 0;
  int            send_calm = 0;
  int            recv_calm = 0;
  key_t          known_keys [$];
  key_t          cluster_base;
  key_t          run_key;

  implicit_array_bst_insert_find u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic key_t rand_key();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    return {hi[KEY_W-33:0], lo};
  endfunction

  function automatic key_t fresh_key(key_style_t style);
    case (style)
      KEYS_CLUSTER: return cluster_base | key_t'($urandom_range(0, 255));
      KEYS_RISING: begin
        run_key = run_key + key_t'($urandom_range(1, 4096));
        return run_key;
      end
      KEYS_FALLING: begin
        run_key = run_key - key_t'($urandom_range(1, 4096));
        return run_key;
      end
      KEYS_NARROW: return key_t'($urandom_range(1, 2047));
      default: return rand_key();
    endcase
  endfunction

  function automatic key_t known_or_fresh(key_style_t style);
    if (known_keys.size() == 0) return fresh_key(style);
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // present one command and hold it until the block takes it
  task automatic send_item(aibst_pkg::cmd_t cmd, key_t key);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
  endtask

  // result side backpressure
  initial begin
    int stall;
    forever begin
      stall = pick_gap(recv_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_command(aibst_pkg::cmd_t'(s_tuser), s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int         random_sent;
    int         ep_len;
    int         pick;
    key_style_t style;
    key_t       k;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tree, zero keys, unused command, extremes
    send_item(aibst_pkg::CMD_FIND, key_t'(5));
    send_item(aibst_pkg::CMD_INSERT, '0);
    send_item(aibst_pkg::CMD_FIND, '0);
    send_item(aibst_pkg::CMD_UNUSED, KEY_MAX);
    send_item(aibst_pkg::CMD_UNUSED, '0);
    send_item(aibst_pkg::CMD_INSERT, KEY_MAX);
    send_item(aibst_pkg::CMD_INSERT, key_t'(1));
    send_item(aibst_pkg::CMD_INSERT, KEY_MAX);
    send_item(aibst_pkg::CMD_FIND, KEY_MAX);
    send_item(aibst_pkg::CMD_FIND, key_t'(1));
    send_item(aibst_pkg::CMD_FIND, key_t'(2));
    send_item(aibst_pkg::CMD_CLEAR, '0);
    send_item(aibst_pkg::CMD_FIND, KEY_MAX);
    send_item(aibst_pkg::CMD_CLEAR, KEY_MAX);
    // rising chain down the right spine until the walk runs off the array
    for (int i = 1; i <= 11; i++) send_item(aibst_pkg::CMD_INSERT, key_t'(i));
    send_item(aibst_pkg::CMD_FIND, key_t'(10));
    send_item(aibst_pkg::CMD_FIND, key_t'(11));
    send_item(aibst_pkg::CMD_INSERT, key_t'(10));

    // random: tree episodes, each opened by a clear
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      style        = key_style_t'($urandom_range(0, 4));
      cluster_base = rand_key() & ~key_t'(12'hFFF);
      if (style == KEYS_FALLING) run_key = KEY_MAX - key_t'($urandom_range(0, 1000));
      else run_key = key_t'($urandom_range(0, 1000));
      send_item(aibst_pkg::CMD_CLEAR, rand_key());
      known_keys.delete();
      random_sent++;
      ep_len = $urandom_range(15, 110);
      repeat (ep_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          k = fresh_key(style);
          send_item(aibst_pkg::CMD_INSERT, k);
          known_keys = {known_keys, k};
        end else if (pick < 57) begin
          send_item(aibst_pkg::CMD_INSERT, known_or_fresh(style));
        end else if (pick < 77) begin
          send_item(aibst_pkg::CMD_FIND, known_or_fresh(style));
        end else if (pick < 89) begin
          send_item(aibst_pkg::CMD_FIND, fresh_key(style));
        end else if (pick < 92) begin
          send_item(pick[0] ? aibst_pkg::CMD_INSERT : aibst_pkg::CMD_FIND, '0);
        end else if (pick < 95) begin
          send_item(aibst_pkg::CMD_UNUSED, rand_key());
        end else if (pick < 96) begin
          send_item(aibst_pkg::CMD_CLEAR, rand_key());
          known_keys.delete();
        end else begin
          send_item(aibst_pkg::CMD_FIND, rand_key());
        end
        random_sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/aibst_pkg.sv
hdl/aibst_ram.sv
hdl/aibst_front.sv
hdl/aibst_back.sv
hdl/implicit_array_bst_insert_find.sv
sim/implicit_array_bst_insert_find_tb.sv
